// ===== rtl/mfs_pkg.sv =====
// Shared types and constants for the median fill of missing samples block.
// No dependencies; used by every module under rtl.
package mfs_pkg;

    localparam int BLOCK_DEPTH = 32;
    localparam int SAMPLE_BITS = 24;
    localparam int HALF_BITS   = SAMPLE_BITS + 1;
    localparam int COUNT_W     = $clog2(BLOCK_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [HALF_BITS-1:0]   half_t;
    typedef logic [COUNT_W-1:0]            count_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEEK,
        ST_EMIT
    } state_t;

    // Controls shared by all cells of the sorting chain.
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } sort_ctrl_t;

    // Controls of one cell of the arrival-order store chain.
    typedef struct packed {
        logic write;
        logic shift;
    } store_ctrl_t;

endpackage

// ===== rtl/mfs_sort_cell.sv =====
// One cell of the insertion sorting chain: holds one present sample in ascending order.
// Depends on mfs_pkg.
module mfs_sort_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  mfs_pkg::sort_ctrl_t ctrl,
    input  mfs_pkg::sample_t    ins_value,
    input  logic                prev_gt,
    input  logic                prev_valid,
    input  mfs_pkg::sample_t    prev_value,
    input  logic                next_valid,
    input  mfs_pkg::sample_t    next_value,
    output mfs_pkg::sample_t    value,
    output logic                valid,
    output logic                gt
);

    mfs_pkg::sample_t value_reg, value_next;
    logic             valid_reg, valid_next;

    // An empty cell counts as greater, so a new value not below any held value lands in the first free slot.
    assign gt    = !valid_reg || (value_reg > ins_value);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.insert) begin
            if (prev_gt) begin
                value_next = prev_value;
            end else if (gt) begin
                value_next = ins_value;
            end
            valid_next = valid_reg | prev_valid;
        end else if (ctrl.shift) begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/mfs_store_cell.sv =====
// One cell of the arrival-order store chain: a sample and its missing mark.
// Depends on mfs_pkg.
module mfs_store_cell (
    input  logic                 aclk,
    input  mfs_pkg::store_ctrl_t ctrl,
    input  mfs_pkg::sample_t     wr_sample,
    input  logic                 wr_missing,
    input  mfs_pkg::sample_t     next_sample,
    input  logic                 next_missing,
    output mfs_pkg::sample_t     sample,
    output logic                 missing
);

    mfs_pkg::sample_t sample_reg, sample_next;
    logic             missing_reg, missing_next;

    assign sample  = sample_reg;
    assign missing = missing_reg;

    always_comb begin
        sample_next  = sample_reg;
        missing_next = missing_reg;
        if (ctrl.write) begin
            sample_next  = wr_sample;
            missing_next = wr_missing;
        end else if (ctrl.shift) begin
            sample_next  = next_sample;
            missing_next = next_missing;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        missing_reg <= missing_next;
    end

endmodule

// ===== rtl/median_fill_missing_samples_unit.sv =====
// Median fill of missing samples: top level with the control sequencer and both cell chains.
// Depends on mfs_pkg, mfs_sort_cell and mfs_store_cell.
//
// The block takes one request per cycle while loading a block of up to BLOCK_DEPTH
// samples. Each present sample is placed in ascending order by a row of sorting cells
// as it arrives, and every sample, present or missing, is kept in arrival order in a
// row of store cells. Requests past the store depth are dropped and reported through
// m_overflowed. The request carrying s_last closes the block: the sorting chain then
// shifts toward its head (P-1)/2 times, P being the number of present samples, and
// a final seek step forms the median in half units from the head cell (odd P) or the
// two head cells (even P). Then one result leaves per cycle while m_ready stays high,
// in arrival order, from the head of the store chain through the output register,
// with missing samples replaced by the median. With no present sample the median is
// 0 and m_none_present is set. s_ready is low from the closing request until the last
// result of the block has entered the output register; the next block may start
// loading while that result still waits to be taken.
module median_fill_missing_samples_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mfs_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                   s_missing,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mfs_pkg::HALF_BITS-1:0]   m_value_half,
    output logic signed [mfs_pkg::HALF_BITS-1:0]   m_median_half,
    output logic                                   m_replaced,
    output logic                                   m_none_present,
    output logic                                   m_overflowed,
    output logic                                   m_last_out
);

    localparam int DEPTH = mfs_pkg::BLOCK_DEPTH;

    mfs_pkg::state_t state_reg, state_next;

    mfs_pkg::count_t loaded_count_reg, loaded_count_next;
    mfs_pkg::count_t present_count_reg, present_count_next;
    mfs_pkg::count_t seek_count_reg, seek_count_next;
    mfs_pkg::count_t present_inc;
    logic            overflow_reg, overflow_next;
    mfs_pkg::half_t  median_reg, median_next;
    logic            none_reg, none_next;

    logic m_valid_reg, m_valid_next;
    mfs_pkg::half_t m_value_half_reg, m_median_half_reg;
    logic m_replaced_reg, m_none_present_reg, m_overflowed_reg, m_last_out_reg;

    logic accept;
    logic has_room;
    logic insert;
    logic out_load;
    logic store_shift;

    mfs_pkg::sort_ctrl_t sort_ctrl;
    mfs_pkg::sample_t    sort_value [DEPTH];
    logic                sort_valid [DEPTH];
    logic                sort_gt    [DEPTH];

    mfs_pkg::store_ctrl_t store_ctrl [DEPTH];
    mfs_pkg::sample_t     store_sample [DEPTH];
    logic                 store_missing [DEPTH];
    mfs_pkg::sample_t     wr_sample;

    assign accept   = s_valid && s_ready;
    assign has_room = loaded_count_reg < mfs_pkg::count_t'(DEPTH);
    assign insert   = accept && has_room && !s_missing;
    assign out_load = (state_reg == mfs_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
    // Missing samples are stored as zero; they are replaced on the way out anyway.
    assign wr_sample = s_missing ? '0 : s_sample;
    assign present_inc = present_count_reg + mfs_pkg::count_t'(insert);

    // Sorting chain: cell 0 holds the smallest present sample.
    for (genvar i = 0; i < DEPTH; i++) begin : g_sort
        logic             prev_gt_w, prev_valid_w, next_valid_w;
        mfs_pkg::sample_t prev_value_w, next_value_w;

        if (i == 0) begin : g_head
            assign prev_gt_w    = 1'b0;
            assign prev_valid_w = 1'b1;
            assign prev_value_w = '0;
        end else begin : g_body
            assign prev_gt_w    = sort_gt[i-1];
            assign prev_valid_w = sort_valid[i-1];
            assign prev_value_w = sort_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_valid_w = 1'b0;
            assign next_value_w = '0;
        end else begin : g_link
            assign next_valid_w = sort_valid[i+1];
            assign next_value_w = sort_value[i+1];
        end

        mfs_sort_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (sort_ctrl),
            .ins_value  (s_sample),
            .prev_gt    (prev_gt_w),
            .prev_valid (prev_valid_w),
            .prev_value (prev_value_w),
            .next_valid (next_valid_w),
            .next_value (next_value_w),
            .value      (sort_value[i]),
            .valid      (sort_valid[i]),
            .gt         (sort_gt[i])
        );
    end

    // Store chain: written at the load position, shifted toward cell 0 while emitting.
    for (genvar i = 0; i < DEPTH; i++) begin : g_store
        logic             next_missing_w;
        mfs_pkg::sample_t next_sample_w;

        if (i == DEPTH - 1) begin : g_tail
            assign next_missing_w = 1'b0;
            assign next_sample_w  = '0;
        end else begin : g_link
            assign next_missing_w = store_missing[i+1];
            assign next_sample_w  = store_sample[i+1];
        end

        assign store_ctrl[i].write = accept && has_room
                                     && (loaded_count_reg == mfs_pkg::count_t'(i));
        assign store_ctrl[i].shift = store_shift;

        mfs_store_cell u_cell (
            .aclk         (aclk),
            .ctrl         (store_ctrl[i]),
            .wr_sample    (wr_sample),
            .wr_missing   (s_missing),
            .next_sample  (next_sample_w),
            .next_missing (next_missing_w),
            .sample       (store_sample[i]),
            .missing      (store_missing[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfs_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next         = state_reg;
        loaded_count_next  = loaded_count_reg;
        present_count_next = present_count_reg;
        seek_count_next    = seek_count_reg;
        overflow_next      = overflow_reg;
        median_next        = median_reg;
        none_next          = none_reg;
        s_ready            = 1'b0;
        store_shift        = 1'b0;
        sort_ctrl          = '0;

        case (state_reg)
            mfs_pkg::ST_LOAD: begin
                s_ready          = 1'b1;
                sort_ctrl.insert = insert;
                if (accept) begin
                    present_count_next = present_inc;
                    if (has_room) begin
                        loaded_count_next = loaded_count_reg + mfs_pkg::count_t'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_last) begin
                        // Shifting (P-1)/2 times brings the lower middle value to cell 0.
                        if (present_inc == '0) begin
                            seek_count_next = '0;
                        end else begin
                            seek_count_next = (present_inc - mfs_pkg::count_t'(1)) >> 1;
                        end
                        state_next = mfs_pkg::ST_SEEK;
                    end
                end
            end
            mfs_pkg::ST_SEEK: begin
                if (seek_count_reg != '0) begin
                    sort_ctrl.shift = 1'b1;
                    seek_count_next = seek_count_reg - mfs_pkg::count_t'(1);
                end else begin
                    none_next = (present_count_reg == '0);
                    if (present_count_reg == '0) begin
                        median_next = '0;
                    end else if (present_count_reg[0]) begin
                        median_next = {sort_value[0], 1'b0};
                    end else begin
                        median_next = mfs_pkg::half_t'(sort_value[0])
                                      + mfs_pkg::half_t'(sort_value[1]);
                    end
                    state_next = mfs_pkg::ST_EMIT;
                end
            end
            mfs_pkg::ST_EMIT: begin
                if (out_load) begin
                    store_shift       = 1'b1;
                    loaded_count_next = loaded_count_reg - mfs_pkg::count_t'(1);
                    if (loaded_count_reg == mfs_pkg::count_t'(1)) begin
                        present_count_next = '0;
                        overflow_next      = 1'b0;
                        sort_ctrl.clear    = 1'b1;
                        state_next         = mfs_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = mfs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_count_reg  <= '0;
            present_count_reg <= '0;
            seek_count_reg    <= '0;
            overflow_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            loaded_count_reg  <= loaded_count_next;
            present_count_reg <= present_count_next;
            seek_count_reg    <= seek_count_next;
            overflow_reg      <= overflow_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Output register payload, loaded from the head of the store chain.
    always_ff @(posedge aclk) begin
        median_reg <= median_next;
        none_reg   <= none_next;
        if (out_load) begin
            m_value_half_reg   <= store_missing[0] ? median_reg : {store_sample[0], 1'b0};
            m_median_half_reg  <= median_reg;
            m_replaced_reg     <= store_missing[0];
            m_none_present_reg <= none_reg;
            m_overflowed_reg   <= overflow_reg;
            m_last_out_reg     <= (loaded_count_reg == mfs_pkg::count_t'(1));
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_value_half   = m_value_half_reg;
    assign m_median_half  = m_median_half_reg;
    assign m_replaced     = m_replaced_reg;
    assign m_none_present = m_none_present_reg;
    assign m_overflowed   = m_overflowed_reg;
    assign m_last_out     = m_last_out_reg;

    // While loading, the sorting chain never holds more samples than the store.
    a_present_le_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfs_pkg::ST_LOAD) |-> (present_count_reg <= loaded_count_reg))
        else $error("present count exceeds loaded count");

    // Emission always has at least one stored sample left.
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfs_pkg::ST_EMIT) |-> (loaded_count_reg != '0))
        else $error("emission with an empty store");

    // Handing out the final result of a block returns the sequencer to loading.
    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (loaded_count_reg == mfs_pkg::count_t'(1)))
        |=> (state_reg == mfs_pkg::ST_LOAD) && (present_count_reg == '0))
        else $error("block did not close after its final result");

    // Any present sample keeps the head of the sorting chain filled.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == mfs_pkg::ST_LOAD) && (present_count_reg != '0)) |-> sort_valid[0])
        else $error("sorting chain head empty with present samples");

endmodule

// ===== sim/tb_median_fill_missing_samples_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for median_fill_missing_samples_unit: directed and random sample blocks
// with random idling on both channels. Depends on mfs_pkg and the RTL under rtl only.
module tb_median_fill_missing_samples_unit;

    // One sample request as it crosses the input channel.
    typedef struct packed {
        mfs_pkg::sample_t smp;
        logic             miss;
        logic             lst;
    } request_t;

    // One filled sample as it should leave the result channel.
    typedef struct packed {
        mfs_pkg::half_t value_half;
        mfs_pkg::half_t median_half;
        logic           replaced;
        logic           none_present;
        logic           overflowed;
        logic           last_out;
    } fill_result_t;

    // Tracks the block being loaded, works out the filled samples when a block closes,
    // and checks every result that leaves the block against them in order.
    class fill_tracker;
        mfs_pkg::sample_t held_val[mfs_pkg::BLOCK_DEPTH];
        logic             held_gap[mfs_pkg::BLOCK_DEPTH];
        int unsigned      held;
        mfs_pkg::sample_t ranked[$];
        bit               spilled;
        fill_result_t     fill_due[$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      blocks;
        int unsigned      filled;
        int unsigned      spill_blocks;
        int unsigned      empty_blocks;

        function new();
            held = 0;
            spilled = 0;
            errors = 0;
            checked = 0;
            blocks = 0;
            filled = 0;
            spill_blocks = 0;
            empty_blocks = 0;
        endfunction

        function int unsigned pending();
            return fill_due.size();
        endfunction

        function void take_request(request_t rq);
            int unsigned    k;
            int unsigned    h;
            mfs_pkg::half_t med;
            bit             none;
            fill_result_t   r;
            if (held < mfs_pkg::BLOCK_DEPTH) begin
                held_val[held] = rq.miss ? '0 : rq.smp;
                held_gap[held] = rq.miss;
                held++;
                if (!rq.miss) begin
                    k = ranked.size();
                    while (k > 0 && ranked[k-1] > rq.smp) k--;
                    ranked.insert(k, rq.smp);
                end
            end else begin
                spilled = 1'b1;
            end
            if (!rq.lst) return;

            none = (ranked.size() == 0);
            med = '0;
            if (!none) begin
                h = ranked.size() / 2;
                if (ranked.size() % 2 == 1)
                    med = mfs_pkg::half_t'(2 * int'(ranked[h]));
                else
                    med = mfs_pkg::half_t'(int'(ranked[h-1]) + int'(ranked[h]));
            end
            for (int unsigned i = 0; i < held; i++) begin
                r.value_half   = held_gap[i] ? med : mfs_pkg::half_t'(2 * int'(held_val[i]));
                r.median_half  = med;
                r.replaced     = held_gap[i];
                r.none_present = none;
                r.overflowed   = spilled;
                r.last_out     = (i + 1 == held);
                fill_due.push_back(r);
                if (held_gap[i]) filled++;
            end
            blocks++;
            if (spilled) spill_blocks++;
            if (none) empty_blocks++;
            held = 0;
            spilled = 1'b0;
            ranked.delete();
        endfunction

        function void check_field(string name, integer want, integer got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(mfs_pkg::half_t vh, mfs_pkg::half_t mh, logic rep,
                                   logic nonep, logic ovf, logic lo);
            fill_result_t want;
            if (fill_due.size() == 0) begin
                $error("result with nothing pending: value_half %0d", vh);
                errors++;
                return;
            end
            want = fill_due.pop_front();
            check_field("value_half", want.value_half, vh);
            check_field("median_half", want.median_half, mh);
            check_field("replaced", want.replaced, rep);
            check_field("none_present", want.none_present, nonep);
            check_field("overflowed", want.overflowed, ovf);
            check_field("last_out", want.last_out, lo);
            checked++;
        endfunction
    endclass

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    mfs_pkg::sample_t s_sample  = '0;
    logic             s_missing = 1'b0;
    logic             s_last    = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    mfs_pkg::half_t   m_value_half;
    mfs_pkg::half_t   m_median_half;
    logic             m_replaced;
    logic             m_none_present;
    logic             m_overflowed;
    logic             m_last_out;

    fill_tracker board = new();

    median_fill_missing_samples_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_missing      (s_missing),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value_half   (m_value_half),
        .m_median_half  (m_median_half),
        .m_replaced     (m_replaced),
        .m_none_present (m_none_present),
        .m_overflowed   (m_overflowed),
        .m_last_out     (m_last_out)
    );

    always #5 aclk = ~aclk;

    // Idle lengths: mostly none or a short gap, now and then a long stretch. A quiet
    // phase forces back-to-back traffic so the block also runs at full rate.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned roll;
        if (quiet) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sample values mix full-range noise with a narrow band, so that ties and
    // duplicates show up in the sort, and with both extremes of the field.
    function automatic mfs_pkg::sample_t pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) return mfs_pkg::sample_t'($urandom);
        if (roll < 78) return mfs_pkg::sample_t'(int'($urandom_range(16)) - 8);
        if (roll < 88) return {1'b0, {(mfs_pkg::SAMPLE_BITS-1){1'b1}}};
        if (roll < 98) return {1'b1, {(mfs_pkg::SAMPLE_BITS-1){1'b0}}};
        return '0;
    endfunction

    function automatic request_t req(mfs_pkg::sample_t smp, logic miss, logic lst);
        request_t rq;
        rq.smp  = smp;
        rq.miss = miss;
        rq.lst  = lst;
        return rq;
    endfunction

    // Presents one request after an optional idle gap and holds it until the block
    // takes it. Valid is only lowered when a gap is wanted, so back-to-back requests
    // keep it high without a second assignment in the same time step. The caller
    // lowers valid once the stimulus is over.
    task automatic send_request(input request_t rq, input int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= rq.smp;
        s_missing <= rq.miss;
        s_last    <= rq.lst;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.take_request(rq);
    endtask

    // Result side: the ready line idles at random and every accepted result is
    // checked against the oldest pending one. Signals are read right at the edge,
    // so they hold the values that the block saw at that handshake.
    initial begin : result_side
        int unsigned gap;
        bit          quiet;
        int unsigned taken;
        taken = 0;
        quiet = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (taken % 40 == 0) quiet = ($urandom_range(3) == 0);
            gap = pick_gap(quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_result(m_value_half, m_median_half, m_replaced,
                               m_none_present, m_overflowed, m_last_out);
            taken++;
        end
    end

    // Request side: a short directed run, then random blocks until at least 520
    // requests have gone in.
    initial begin : request_side
        request_t         directed[$];
        request_t         rq;
        int unsigned      sent;
        int unsigned      blk;
        int unsigned      len;
        int unsigned      roll;
        int unsigned      gap_pct;
        bit               quiet;
        mfs_pkg::sample_t top_val;
        mfs_pkg::sample_t bot_val;

        top_val = {1'b0, {(mfs_pkg::SAMPLE_BITS-1){1'b1}}};
        bot_val = {1'b1, {(mfs_pkg::SAMPLE_BITS-1){1'b0}}};
        sent = 0;
        blk = 0;

        // A lone present sample at the top of the range.
        directed.push_back(req(top_val, 1'b0, 1'b1));
        // A lone missing sample: no median exists, so it is filled with zero.
        directed.push_back(req(top_val, 1'b1, 1'b1));
        // Two minimum samples averaged, then a missing closer filled with their median.
        directed.push_back(req(bot_val, 1'b0, 1'b0));
        directed.push_back(req(bot_val, 1'b0, 1'b0));
        directed.push_back(req('0, 1'b1, 1'b1));
        // Two maximum samples around a gap: the largest median the block can form.
        directed.push_back(req(top_val, 1'b0, 1'b0));
        directed.push_back(req(bot_val, 1'b1, 1'b0));
        directed.push_back(req(top_val, 1'b0, 1'b1));
        // Even count whose two middle values differ by an odd amount: a half-unit median.
        directed.push_back(req(mfs_pkg::sample_t'(3), 1'b0, 1'b0));
        directed.push_back(req('0, 1'b1, 1'b0));
        directed.push_back(req(mfs_pkg::sample_t'(-7), 1'b0, 1'b0));
        directed.push_back(req(mfs_pkg::sample_t'(10), 1'b0, 1'b0));
        directed.push_back(req('0, 1'b0, 1'b1));
        // A block with nothing present at all.
        directed.push_back(req('1, 1'b1, 1'b0));
        directed.push_back(req(top_val, 1'b1, 1'b0));
        directed.push_back(req(bot_val, 1'b1, 1'b1));
        // Alternating bit patterns, one of them negative, and an odd present count.
        directed.push_back(req(mfs_pkg::sample_t'(24'h555555), 1'b0, 1'b0));
        directed.push_back(req(mfs_pkg::sample_t'(24'hAAAAAA), 1'b0, 1'b0));
        directed.push_back(req(mfs_pkg::sample_t'(-1), 1'b0, 1'b0));
        directed.push_back(req(mfs_pkg::sample_t'(24'h123456), 1'b1, 1'b1));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i], pick_gap(1'b0));
            sent++;
        end

        // Random blocks. Most are short; some fill the store; about one in ten runs
        // past the store depth so that the closing request itself is dropped. The
        // first two random blocks pin the overflow case and the exactly full store.
        while (sent < 520) begin
            quiet = ($urandom_range(4) == 0);
            roll = $urandom_range(99);
            if (blk == 0) len = mfs_pkg::BLOCK_DEPTH + 2;
            else if (blk == 1) len = mfs_pkg::BLOCK_DEPTH;
            else if (roll < 70) len = $urandom_range(1, 10);
            else if (roll < 90) len = $urandom_range(11, mfs_pkg::BLOCK_DEPTH);
            else len = $urandom_range(mfs_pkg::BLOCK_DEPTH + 1, mfs_pkg::BLOCK_DEPTH + 6);
            case ($urandom_range(4))
                0: gap_pct = 0;
                1: gap_pct = 10;
                2: gap_pct = 50;
                3: gap_pct = 90;
                default: gap_pct = 100;
            endcase
            for (int unsigned j = 0; j < len; j++) begin
                rq.smp  = pick_sample();
                rq.miss = ($urandom_range(99) < gap_pct);
                rq.lst  = (j == len - 1);
                send_request(rq, pick_gap(quiet));
                sent++;
            end
            blk++;
            // Now and then hold off entirely until the block has emitted everything,
            // so that a new block also starts from a fully idle unit.
            if (blk == 8 || blk % 25 == 0) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (board.pending() != 0);
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        // Leave room for any stray result that should never have come.
        repeat (60) @(posedge aclk);

        $display("Sent %0d requests in %0d blocks; checked %0d results.",
                 sent, board.blocks, board.checked);
        $display("Filled %0d missing samples; %0d blocks overflowed, %0d had none present.",
                 board.filled, board.spill_blocks, board.empty_blocks);
        if (board.errors == 0) begin
            $display("median_fill_missing_samples_unit: match");
        end else begin
            $display("median_fill_missing_samples_unit: mismatch");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("Timed out with %0d results still pending.", board.pending());
        $display("median_fill_missing_samples_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mfs_pkg.sv
rtl/mfs_sort_cell.sv
rtl/mfs_store_cell.sv
rtl/median_fill_missing_samples_unit.sv
sim/tb_median_fill_missing_samples_unit.sv
